>>> rtl/core/hlf_pkg.sv
// ----------------------------------------------------------------------------
// hlf_pkg
// Shared types and constants of the histogram localisation filter.
// ----------------------------------------------------------------------------
package hlf_pkg;

  localparam int unsigned Cells      = 16;
  localparam int unsigned CellBits   = 4;
  localparam int unsigned ProbBits   = 16;
  localparam int unsigned SymBits    = 4;
  localparam int unsigned GainBits   = 16;
  localparam int unsigned WeightBits = ProbBits + GainBits;      // one product
  localparam int unsigned SumBits    = WeightBits + CellBits + 2; // sense sum / move acc
  localparam int unsigned QuotBits   = ProbBits + 2;             // quotient, enough to saturate
  localparam int unsigned AddrBits   = 3;

  localparam logic [ProbBits-1:0] ProbMax    = '1;
  localparam logic [ProbBits-1:0] BeliefInit = ProbBits'(4096);

  typedef enum logic [1:0] {
    CmdLoadMap    = 2'd0,
    CmdLoadBelief = 2'd1,
    CmdSense      = 2'd2,
    CmdMove       = 2'd3
  } cmd_e;

  typedef enum logic [AddrBits-1:0] {
    RegHit   = 3'd0,
    RegMiss  = 3'd1,
    RegExact = 3'd2,
    RegOver  = 3'd3,
    RegUnder = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StSenseW,     // weight one cell per cycle
    StSenseChk,
    StDivInit,
    StDivRun,     // restoring division, one bit per cycle
    StDivWr,
    StMoveE,      // exact tap
    StMoveO,      // overshoot tap
    StMoveU,      // undershoot tap
    StMoveWr,
    StCopy,       // new belief back into belief store
    StReport
  } state_e;

  typedef struct packed {
    logic clr_idx;
    logic inc_idx;
    logic sense_acc;
    logic div_init;
    logic div_step;
    logic div_wr;
    logic tap_e;
    logic tap_o;
    logic tap_u;
    logic move_wr;
    logic copy;
    logic set_status;
    logic clr_status;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic idx_last;
    logic sum_zero;
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [CellBits-1:0] cell_index;
    logic [SymBits-1:0]  symbol;
    logic [ProbBits-1:0] probability;
    logic signed [15:0]  shift;
  } in_item_t;

  typedef struct packed {
    logic [CellBits-1:0] out_index;
    logic [ProbBits-1:0] out_probability;
    logic                last;
    logic                status;
  } out_item_t;

endpackage

>>> rtl/core/hlf_if.sv
// ----------------------------------------------------------------------------
// hlf_in_if / hlf_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface hlf_in_if;
  logic              valid;
  logic              ready;
  hlf_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hlf_out_if;
  logic               valid;
  logic               ready;
  hlf_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/histogram_localization_filter.sv
// Load items are written when accepted and give no result.
// Sense: the 16 cells are weighted and the sum checked; unless it is zero, each cell runs
// through the serial divider (one quotient bit per cycle) and is copied back; then a report.
// Move: exact, overshoot and undershoot taps a cell through the shared multiplier and a write, then copy and report.
// Throughput: one request at a time, the next taken once the last result is loaded.
// Reset (asynchronous, active low): gains to defaults, belief 4096, map 0.
// ----------------------------------------------------------------------------
// histogram_localization_filter
// Cyclic discrete Bayes filter with APB gain registers.
// ----------------------------------------------------------------------------
module histogram_localization_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  hlf_in_if.sink      in_if,
  hlf_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [hlf_pkg::AddrBits+1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] hit_q, miss_q, exact_q, over_q, under_q;
  logic        idle, in_acc, start_s, start_m, out_free, ovalid_q;
  logic [hlf_pkg::AddrBits-1:0] reg_a;
  hlf_pkg::ctrl_t ctrl;
  hlf_pkg::stat_t stat;
  hlf_pkg::out_item_t oitem;

  assign pready = 1'b1;
  assign reg_a  = paddr[hlf_pkg::AddrBits+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 16'd39322;
      miss_q  <= 16'd13107;
      exact_q <= 16'd52429;
      over_q  <= 16'd6554;
      under_q <= 16'd6554;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_a)
        hlf_pkg::RegHit:   hit_q   <= pwdata[15:0];
        hlf_pkg::RegMiss:  miss_q  <= pwdata[15:0];
        hlf_pkg::RegExact: exact_q <= pwdata[15:0];
        hlf_pkg::RegOver:  over_q  <= pwdata[15:0];
        hlf_pkg::RegUnder: under_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_a)
      hlf_pkg::RegHit:   prdata = {16'd0, hit_q};
      hlf_pkg::RegMiss:  prdata = {16'd0, miss_q};
      hlf_pkg::RegExact: prdata = {16'd0, exact_q};
      hlf_pkg::RegOver:  prdata = {16'd0, over_q};
      hlf_pkg::RegUnder: prdata = {16'd0, under_q};
      default:           prdata = '0;
    endcase
  end

  assign in_if.ready = idle;
  assign in_acc  = in_if.valid && idle;
  assign start_s = in_acc && in_if.payload.command == hlf_pkg::CmdSense;
  assign start_m = in_acc && in_if.payload.command == hlf_pkg::CmdMove;
  assign out_free = !ovalid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_if.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  assign out_if.valid   = ovalid_q;
  assign out_if.payload = oitem;

  hlf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_sense_i(start_s), .start_move_i(start_m),
    .out_free_i(out_free), .stat_i(stat), .ctrl_o(ctrl), .idle_o(idle)
  );

  hlf_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .load_map_i(in_acc && in_if.payload.command == hlf_pkg::CmdLoadMap),
    .load_bel_i(in_acc && in_if.payload.command == hlf_pkg::CmdLoadBelief),
    .latch_i(start_s || start_m), .item_i(in_if.payload),
    .hit_i(hit_q), .miss_i(miss_q), .exact_i(exact_q), .over_i(over_q),
    .under_i(under_q), .out_o(oitem)
  );

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle |-> !in_if.ready) else $error("input taken while busy");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |=> out_if.valid) else $error("result not presented");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");

endmodule

>>> rtl/core/hlf_ctrl.sv
// ----------------------------------------------------------------------------
// hlf_ctrl
// Sequencer for the sense, move and report passes.
// ----------------------------------------------------------------------------
module hlf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_sense_i,
  input  logic           start_move_i,
  input  logic           out_free_i,
  input  hlf_pkg::stat_t stat_i,
  output hlf_pkg::ctrl_t ctrl_o,
  output logic           idle_o
);

  hlf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hlf_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hlf_pkg::StIdle: begin
        if (start_sense_i) begin
          state_d = hlf_pkg::StSenseW;
        end else if (start_move_i) begin
          state_d = hlf_pkg::StMoveE;
        end
      end
      hlf_pkg::StSenseW:   if (stat_i.idx_last) state_d = hlf_pkg::StSenseChk;
      hlf_pkg::StSenseChk: state_d = stat_i.sum_zero ? hlf_pkg::StReport : hlf_pkg::StDivInit;
      hlf_pkg::StDivInit:  state_d = hlf_pkg::StDivRun;
      hlf_pkg::StDivRun:   if (stat_i.div_done) state_d = hlf_pkg::StDivWr;
      hlf_pkg::StDivWr:    state_d = stat_i.idx_last ? hlf_pkg::StCopy : hlf_pkg::StDivInit;
      hlf_pkg::StMoveE:    state_d = hlf_pkg::StMoveO;
      hlf_pkg::StMoveO:    state_d = hlf_pkg::StMoveU;
      hlf_pkg::StMoveU:    state_d = hlf_pkg::StMoveWr;
      hlf_pkg::StMoveWr:   state_d = stat_i.idx_last ? hlf_pkg::StCopy : hlf_pkg::StMoveE;
      hlf_pkg::StCopy:     if (stat_i.idx_last) state_d = hlf_pkg::StReport;
      hlf_pkg::StReport: begin
        if (out_free_i && stat_i.idx_last) state_d = hlf_pkg::StIdle;
      end
      default: state_d = hlf_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      hlf_pkg::StIdle: begin
        ctrl_o.clr_idx = 1'b1;
        ctrl_o.clr_status = start_sense_i | start_move_i;
      end
      hlf_pkg::StSenseW: begin
        ctrl_o.sense_acc = 1'b1;
        ctrl_o.inc_idx = 1'b1;
      end
      hlf_pkg::StSenseChk: begin
        ctrl_o.clr_idx = 1'b1;
        ctrl_o.set_status = stat_i.sum_zero;
      end
      hlf_pkg::StDivInit: ctrl_o.div_init = 1'b1;
      hlf_pkg::StDivRun:  ctrl_o.div_step = 1'b1;
      hlf_pkg::StDivWr: begin
        ctrl_o.div_wr = 1'b1;
        ctrl_o.inc_idx = 1'b1;
      end
      hlf_pkg::StMoveE: ctrl_o.tap_e = 1'b1;
      hlf_pkg::StMoveO: ctrl_o.tap_o = 1'b1;
      hlf_pkg::StMoveU: ctrl_o.tap_u = 1'b1;
      hlf_pkg::StMoveWr: begin
        ctrl_o.move_wr = 1'b1;
        ctrl_o.inc_idx = 1'b1;
      end
      hlf_pkg::StCopy: begin
        ctrl_o.copy = 1'b1;
        ctrl_o.inc_idx = 1'b1;
      end
      hlf_pkg::StReport: begin
        ctrl_o.out_load = out_free_i;
        ctrl_o.inc_idx = out_free_i;
      end
      default: ;
    endcase
  end

  assign idle_o = (state_q == hlf_pkg::StIdle);

endmodule

>>> rtl/core/hlf_dp.sv
// ----------------------------------------------------------------------------
// hlf_dp
// Belief, map and scratch stores, multiplier, accumulator and serial divider.
// ----------------------------------------------------------------------------
module hlf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hlf_pkg::ctrl_t                      ctrl_i,
  output hlf_pkg::stat_t                      stat_o,
  input  logic                                load_map_i,
  input  logic                                load_bel_i,
  input  logic                                latch_i,
  input  hlf_pkg::in_item_t                   item_i,
  input  logic [hlf_pkg::GainBits-1:0]        hit_i,
  input  logic [hlf_pkg::GainBits-1:0]        miss_i,
  input  logic [hlf_pkg::GainBits-1:0]        exact_i,
  input  logic [hlf_pkg::GainBits-1:0]        over_i,
  input  logic [hlf_pkg::GainBits-1:0]        under_i,
  output hlf_pkg::out_item_t                  out_o
);

  localparam int unsigned CB = hlf_pkg::CellBits;
  localparam int unsigned PB = hlf_pkg::ProbBits;
  localparam int unsigned SB = hlf_pkg::SumBits;
  localparam int unsigned WB = hlf_pkg::WeightBits;
  localparam int unsigned QB = hlf_pkg::QuotBits;
  // w * 2^PB + sum/2 can carry into one bit above the product
  localparam int unsigned DivSteps = WB + PB + 1;

  // belief and map are small register files, reset to their initial values
  logic [PB-1:0]                  belief_q [hlf_pkg::Cells];
  logic [hlf_pkg::SymBits-1:0]    map_q    [hlf_pkg::Cells];
  logic [WB-1:0]                  scratch_q [hlf_pkg::Cells];
  logic [PB-1:0]                  newb_q   [hlf_pkg::Cells];

  logic [CB-1:0]                  idx_q;
  logic [hlf_pkg::SymBits-1:0]    sym_q;
  logic [CB-1:0]                  shift_q;
  logic [SB-1:0]                  acc_q;
  logic [SB-1:0]                  sum_q;
  logic                           status_q;
  logic [SB:0]                    rem_q;
  logic [DivSteps-1:0]            dvd_q;
  logic [QB-1:0]                  quo_q;
  logic [$clog2(DivSteps+1)-1:0]  cnt_q;

  logic [CB-1:0]                  rd_idx;
  logic [PB-1:0]                  mul_b;
  logic [hlf_pkg::GainBits-1:0]   mul_g;
  logic [WB-1:0]                  prod;
  logic [SB:0]                    rem_sh;
  logic [SB-1:0]                  acc_rnd;
  logic [SB-1:0]                  mv_val;
  logic [SB-1:0]                  q_rnd;

  // tap address: i - u, minus one for overshoot, plus one for undershoot
  always_comb begin
    rd_idx = idx_q - shift_q;
    mul_g  = exact_i;
    if (ctrl_i.tap_o) begin
      rd_idx = idx_q - shift_q - CB'(1);
      mul_g  = over_i;
    end else if (ctrl_i.tap_u) begin
      rd_idx = idx_q - shift_q + CB'(1);
      mul_g  = under_i;
    end else if (ctrl_i.sense_acc) begin
      rd_idx = idx_q;
      mul_g  = (map_q[idx_q] == sym_q) ? hit_i : miss_i;
    end
    mul_b = belief_q[rd_idx];
    prod  = WB'(mul_b) * WB'(mul_g);
  end

  assign rem_sh  = {rem_q[SB-1:0], dvd_q[DivSteps-1]};
  assign acc_rnd = acc_q + SB'(1 << (hlf_pkg::GainBits - 1));
  assign mv_val  = acc_rnd >> hlf_pkg::GainBits;
  assign q_rnd   = SB'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      status_q <= 1'b0;
      cnt_q    <= '0;
      for (int i = 0; i < hlf_pkg::Cells; i++) begin
        belief_q[i] <= hlf_pkg::BeliefInit;
        map_q[i]    <= '0;
      end
    end else begin
      if (load_map_i) map_q[item_i.cell_index] <= item_i.symbol;
      if (load_bel_i) belief_q[item_i.cell_index] <= item_i.probability;
      if (ctrl_i.clr_idx) begin
        idx_q <= '0;
      end else if (ctrl_i.inc_idx) begin
        idx_q <= idx_q + CB'(1);
      end
      if (ctrl_i.clr_status) status_q <= 1'b0;
      if (ctrl_i.set_status) status_q <= 1'b1;
      if (ctrl_i.div_init) begin
        cnt_q <= '0;
      end else if (ctrl_i.div_step) begin
        cnt_q <= cnt_q + ($bits(cnt_q))'(1);
      end
      if (ctrl_i.copy) belief_q[idx_q] <= newb_q[idx_q];
    end
  end

  // payload, accumulator, divider and output registers
  always_ff @(posedge clk_i) begin
    if (latch_i) begin
      sym_q   <= item_i.symbol;
      shift_q <= item_i.shift[CB-1:0]; // true modulo of a power-of-two count
      acc_q   <= '0;
    end
    if (ctrl_i.sense_acc) begin
      scratch_q[idx_q] <= prod;
      acc_q            <= acc_q + SB'(prod);
    end
    if (ctrl_i.tap_e) acc_q <= SB'(prod);
    if (ctrl_i.tap_o || ctrl_i.tap_u) acc_q <= acc_q + SB'(prod);
    if (ctrl_i.move_wr) begin
      newb_q[idx_q] <= (mv_val > SB'(hlf_pkg::ProbMax)) ? hlf_pkg::ProbMax : mv_val[PB-1:0];
    end
    if (ctrl_i.set_status || ctrl_i.clr_idx) sum_q <= acc_q;
    // dividend = w * 2^PB + sum/2; run as restoring division
    if (ctrl_i.div_init) begin
      dvd_q <= {1'b0, scratch_q[idx_q], PB'(0)} + DivSteps'(sum_q >> 1);
      rem_q <= '0;
      quo_q <= '0;
    end else if (ctrl_i.div_step) begin
      dvd_q <= {dvd_q[DivSteps-2:0], 1'b0};
      if (rem_sh >= {1'b0, sum_q}) begin
        rem_q <= rem_sh - {1'b0, sum_q};
        quo_q <= quo_q[QB-1] ? '1 : {quo_q[QB-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= quo_q[QB-1] ? '1 : {quo_q[QB-2:0], 1'b0};
      end
    end
    if (ctrl_i.div_wr) begin
      newb_q[idx_q] <= (q_rnd > SB'(hlf_pkg::ProbMax)) ? hlf_pkg::ProbMax : quo_q[PB-1:0];
    end
    if (ctrl_i.out_load) begin
      out_o.out_index       <= idx_q;
      out_o.out_probability <= belief_q[idx_q];
      out_o.last            <= (idx_q == CB'(hlf_pkg::Cells - 1));
      out_o.status          <= status_q;
    end
  end

  assign stat_o.idx_last = (idx_q == CB'(hlf_pkg::Cells - 1));
  assign stat_o.sum_zero = (acc_q == '0);
  // the step taken in the done cycle is the last quotient bit
  assign stat_o.div_done = (cnt_q == ($bits(cnt_q))'(DivSteps - 1));

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the histogram localisation filter: directed table and cases,
// then random load/sense/move traffic, checked against a behavioural predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandItems  = 300;
  localparam int unsigned InBits     = $bits(hlf_pkg::in_item_t);

  typedef struct {
    hlf_pkg::in_item_t            req;
    bit                           typed;
    logic [hlf_pkg::ProbBits-1:0] prob;
    logic                         stat;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [hlf_pkg::AddrBits+1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hlf_in_if  in_if ();
  hlf_out_if out_if ();

  histogram_localization_filter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [hlf_pkg::ProbBits-1:0] belief_m [hlf_pkg::Cells];
  logic [hlf_pkg::SymBits-1:0]  map_m    [hlf_pkg::Cells];
  logic [15:0]                  gain_m   [5];
  hlf_pkg::out_item_t           belief_q [$];

  // typed expectation for the directed row in flight
  bit                           typed_on;
  logic [hlf_pkg::ProbBits-1:0] typed_prob;
  logic                         typed_stat;

  int unsigned fails;
  int unsigned cycles;
  int unsigned hold_cnt;
  bit          in_burst, out_burst;

  function automatic void push_report(logic stat);
    hlf_pkg::out_item_t r;
    for (int i = 0; i < hlf_pkg::Cells; i++) begin
      r.out_index       = hlf_pkg::CellBits'(i);
      r.out_probability = typed_on ? typed_prob : belief_m[i];
      r.last            = (i == hlf_pkg::Cells - 1);
      r.status          = typed_on ? typed_stat : stat;
      belief_q.push_back(r);
    end
  endfunction

  function automatic void filter_update(hlf_pkg::in_item_t req);
    logic [63:0] w [hlf_pkg::Cells];
    logic [63:0] sum, q, acc;
    logic [3:0]  u;
    logic [hlf_pkg::ProbBits-1:0] nb [hlf_pkg::Cells];
    case (hlf_pkg::cmd_e'(req.command))
      hlf_pkg::CmdLoadMap:    map_m[req.cell_index] = req.symbol;
      hlf_pkg::CmdLoadBelief: belief_m[req.cell_index] = req.probability;
      hlf_pkg::CmdSense: begin
        sum = '0;
        for (int i = 0; i < hlf_pkg::Cells; i++) begin
          w[i] = 64'(belief_m[i]) *
                 64'((map_m[i] == req.symbol) ? gain_m[hlf_pkg::RegHit]
                                               : gain_m[hlf_pkg::RegMiss]);
          sum += w[i];
        end
        if (sum == 0) begin
          push_report(1'b1);
        end else begin
          for (int i = 0; i < hlf_pkg::Cells; i++) begin
            q = ((w[i] << hlf_pkg::ProbBits) + (sum >> 1)) / sum;
            belief_m[i] = (q > 64'(hlf_pkg::ProbMax)) ? hlf_pkg::ProbMax
                                                      : q[hlf_pkg::ProbBits-1:0];
          end
          push_report(1'b0);
        end
      end
      default: begin
        // cell count is a power of two, so the low bits give a true modulo
        u = req.shift[3:0];
        for (int i = 0; i < hlf_pkg::Cells; i++) begin
          acc = 64'(gain_m[hlf_pkg::RegExact]) * belief_m[4'(i - u)]
              + 64'(gain_m[hlf_pkg::RegOver])  * belief_m[4'(i - u - 1)]
              + 64'(gain_m[hlf_pkg::RegUnder]) * belief_m[4'(i - u + 1)];
          acc = (acc + 64'd32768) >> 16;
          nb[i] = (acc > 64'(hlf_pkg::ProbMax)) ? hlf_pkg::ProbMax
                                                : acc[hlf_pkg::ProbBits-1:0];
        end
        belief_m = nb;
        push_report(1'b0);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) filter_update(in_if.payload);
  end

  always @(posedge clk_i) begin
    hlf_pkg::out_item_t got, want;
    if (out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (belief_q.size() == 0) begin
        $error("unexpected result: index %0d prob %0d", got.out_index, got.out_probability);
        fails++;
      end else begin
        want = belief_q.pop_front();
        if (got.out_index !== want.out_index) begin
          $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
          fails++;
        end
        if (got.out_probability !== want.out_probability) begin
          $error("out_probability: expected %0d, got %0d",
                 want.out_probability, got.out_probability);
          fails++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          fails++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, got.status);
          fails++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when hold_cnt is loaded
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_if.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_if.ready <= out_burst || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(hlf_pkg::reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {16'($urandom), val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    gain_m[idx] = val;
  endtask

  task automatic set_gains(logic [15:0] h, logic [15:0] m, logic [15:0] e,
                           logic [15:0] o, logic [15:0] un);
    reg_write(hlf_pkg::RegHit, h);
    reg_write(hlf_pkg::RegMiss, m);
    reg_write(hlf_pkg::RegExact, e);
    reg_write(hlf_pkg::RegOver, o);
    reg_write(hlf_pkg::RegUnder, un);
  endtask

  task automatic send(hlf_pkg::in_item_t req);
    @(negedge clk_i);
    while (!in_burst && $urandom_range(99) < 38) begin
      in_if.valid = 1'b0;
      in_if.payload = hlf_pkg::in_item_t'(InBits'({$urandom, $urandom}));
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.payload = req;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (belief_q.size() != 0) @(posedge clk_i);
    // load items leave no trace in the result stream
    repeat (60) @(posedge clk_i);
  endtask

  function automatic row_t mk(hlf_pkg::cmd_e c, int idx, int sym, int prob, int sh,
                              bit typed = 0, int tp = 0, bit ts = 0);
    row_t r;
    r.req.command     = c;
    r.req.cell_index  = hlf_pkg::CellBits'(idx);
    r.req.symbol      = hlf_pkg::SymBits'(sym);
    r.req.probability = hlf_pkg::ProbBits'(prob);
    r.req.shift       = 16'(sh);
    r.typed = typed;
    r.prob  = hlf_pkg::ProbBits'(tp);
    r.stat  = ts;
    return r;
  endfunction

  function automatic hlf_pkg::in_item_t rand_req();
    hlf_pkg::in_item_t r;
    int unsigned p;
    r = hlf_pkg::in_item_t'(InBits'({$urandom, $urandom}));
    p = $urandom_range(99);
    if (p < 40)      r.command = hlf_pkg::CmdLoadMap;
    else if (p < 70) r.command = hlf_pkg::CmdLoadBelief;
    else if (p < 85) r.command = hlf_pkg::CmdSense;
    else             r.command = hlf_pkg::CmdMove;
    if ($urandom_range(9) == 0) begin
      r.probability = ($urandom_range(1)) ? '0 : hlf_pkg::ProbMax;
    end
    return r;
  endfunction

  initial begin
    row_t tbl [$];
    hlf_pkg::in_item_t req;
    int unsigned n;

    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    typed_on = 0; typed_prob = '0; typed_stat = 1'b0;
    fails = 0; cycles = 0; hold_cnt = 0;
    in_burst = 0; out_burst = 0;
    for (int i = 0; i < hlf_pkg::Cells; i++) begin
      belief_m[i] = hlf_pkg::BeliefInit;
      map_m[i] = '0;
    end
    gain_m[hlf_pkg::RegHit] = 16'd39322;  gain_m[hlf_pkg::RegMiss] = 16'd13107;
    gain_m[hlf_pkg::RegExact] = 16'd52429; gain_m[hlf_pkg::RegOver] = 16'd6554;
    gain_m[hlf_pkg::RegUnder] = 16'd6554;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // uniform belief, uniform map: sense gives the same uniform belief back
    tbl.push_back(mk(hlf_pkg::CmdSense, 0, 0, 0, 0, 1, 4096, 0));
    tbl.push_back(mk(hlf_pkg::CmdMove, 0, 0, 0, 0, 1, 4096, 0));
    tbl.push_back(mk(hlf_pkg::CmdLoadMap, 0, 15, 0, 0));
    tbl.push_back(mk(hlf_pkg::CmdLoadMap, 15, 5, 0, 0));
    tbl.push_back(mk(hlf_pkg::CmdLoadBelief, 0, 0, 65535, 0));
    tbl.push_back(mk(hlf_pkg::CmdLoadBelief, 15, 0, 0, 0));
    tbl.push_back(mk(hlf_pkg::CmdSense, 0, 15, 0, 0));
    tbl.push_back(mk(hlf_pkg::CmdSense, 0, 5, 0, 0));
    tbl.push_back(mk(hlf_pkg::CmdMove, 0, 0, 0, 1));
    tbl.push_back(mk(hlf_pkg::CmdMove, 0, 0, 0, -1));
    tbl.push_back(mk(hlf_pkg::CmdMove, 0, 0, 0, 32767));
    tbl.push_back(mk(hlf_pkg::CmdMove, 0, 0, 0, -32768));
    tbl.push_back(mk(hlf_pkg::CmdMove, 0, 0, 0, 17));
    tbl.push_back(mk(hlf_pkg::CmdMove, 0, 0, 0, -17));
    tbl.push_back(mk(hlf_pkg::CmdLoadBelief, 0, 0, 65535, 0));
    // typed values change after the predictor has sampled the accepting edge
    foreach (tbl[k]) begin
      typed_on <= tbl[k].typed; typed_prob <= tbl[k].prob; typed_stat <= tbl[k].stat;
      send(tbl[k].req);
    end
    typed_on <= 0;
    drain();

    // zero weight sum: belief kept, status flagged
    set_gains(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(mk(hlf_pkg::CmdSense, 0, 3, 0, 0).req);
    drain();

    // only cell 0 matches: its weight equals the sum and saturates
    set_gains(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(mk(hlf_pkg::CmdSense, 0, 15, 0, 0).req);
    for (int i = 0; i < hlf_pkg::Cells; i++) begin
      send(mk(hlf_pkg::CmdLoadBelief, i, 0, 65535, 0).req);
    end
    send(mk(hlf_pkg::CmdMove, 0, 0, 0, 3).req);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_gains(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        1: set_gains(16'd0, 16'hFFFF, 16'h8000, 16'h4000, 16'h4000);
        default: set_gains(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
      endcase
      in_burst = (ph == 2);
      out_burst = (ph == 2);
      // long receiver hold-off so the block backs up into its input
      if (ph == 3) hold_cnt = 1500;
      n = RandItems / 5;
      for (int k = 0; k < n; k++) begin
        req = rand_req();
        send(req);
      end
      in_burst = 0;
      out_burst = 0;
      drain();
    end

    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
